@@ rtl/assert_macros.svh @@
// Assertion helpers, included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, muted while in reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: label");

// Same, for a property that must also hold during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed: label");

`endif

@@ rtl/hvt_pkg.sv @@
package hvt_pkg;

    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 8;
    localparam int QUO_W     = 33;  // quotient bits kept by the divider

    // One division lane travelling down the divider.
    typedef struct packed {
        logic [63:0]      rem;
        logic [QUO_W-1:0] quo;
        logic             neg;   // numerator sign
        logic             over;  // quotient known to be >= 2^33
    } div_lane_t;

    // Everything one item carries through the divider stages.
    typedef struct packed {
        div_lane_t [2:0] lane;
        logic [63:0]     den;
        logic            den_neg;
        logic            w_zero;
    } div_pipe_t;

endpackage

@@ rtl/hvt_row_mac.sv @@
// One matrix row: four products, then the exact row sum as sign and magnitude.
module hvt_row_mac #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               valid_in,
    input  logic signed [31:0] c0,
    input  logic signed [31:0] c1,
    input  logic signed [31:0] c2,
    input  logic signed [31:0] c3,
    input  logic signed [31:0] px,
    input  logic signed [31:0] py,
    input  logic signed [31:0] pz,
    output logic               valid_out,
    output logic [63:0]        mag,
    output logic               neg
);

    logic signed [63:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic               v1_reg, v2_reg;
    logic [63:0]        mag_reg;
    logic               neg_reg;
    logic signed [65:0] sum;

    // Stage 1: products; w is 1.0 so column 3 is a shift
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg <= c0 * px;
            p1_reg <= c1 * py;
            p2_reg <= c2 * pz;
            p3_reg <= 64'(c3) <<< FRAC_BITS;
        end
    end

    // Stage 2: row sum, magnitude stays below 2^64
    assign sum = 66'(p0_reg) + 66'(p1_reg) + 66'(p2_reg) + 66'(p3_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg <= sum[65];
            mag_reg <= sum[65] ? (64'd0 - sum[63:0]) : sum[63:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
        end
    end

    assign valid_out = v2_reg;
    assign mag       = mag_reg;
    assign neg       = neg_reg;

endmodule

@@ rtl/hvt_div_step.sv @@
// One restoring division step for all three lanes, quotient bit STEP.
module hvt_div_step #(
    parameter int STEP = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid_in,
    input  hvt_pkg::div_pipe_t pipe_in,
    output logic              valid_out,
    output hvt_pkg::div_pipe_t pipe_out
);

    hvt_pkg::div_pipe_t pipe_next, pipe_reg;
    logic               valid_reg;

    // Trial subtract of den shifted up by STEP
    always_comb
    begin
        logic take;
        pipe_next = pipe_in;
        for (int l = 0; l < 3; l++)
        begin
            take = (pipe_in.lane[l].rem >> STEP) >= pipe_in.den;
            if (take)
            begin
                pipe_next.lane[l].rem = pipe_in.lane[l].rem - (pipe_in.den << STEP);
            end
            pipe_next.lane[l].quo = {pipe_in.lane[l].quo[hvt_pkg::QUO_W-2:0], take};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_reg <= pipe_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    assign valid_out = valid_reg;
    assign pipe_out  = pipe_reg;

endmodule

@@ rtl/homogeneous_vertex_transform_top.sv @@
// Transforms one Q-format point (x, y, z, 1) by a 4x4 matrix and divides rows
// 0..2 by row 3 with ceiling rounding and 32-bit saturation. One point enters
// per cycle unless the pipeline holds; the pipeline registers the products, the
// row sums, the divider setup, each bit-per-stage divider step and the rounded
// output. The whole pipeline holds while a result waits on m_tready. The user
// must write the matrix through cfg_* (index 0..7, others ignored) only while
// idle; the block itself does not enforce it. Reset loads the identity matrix.
`include "assert_macros.svh"

module homogeneous_vertex_transform_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [95:0]                   s_tdata,   // point_x, point_y, point_z
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [95:0]                   m_tdata,   // screen_x, screen_y, screen_depth
    output logic [1:0]                    m_tuser,   // w_was_zero, clamped
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hvt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data
);

    localparam int NDIV = hvt_pkg::QUO_W;
    localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

    logic [63:0] regs_reg [hvt_pkg::NUM_REGS];
    logic        en;
    logic [3:0]  row_valid;
    logic [63:0] mag [4];
    logic        neg [4];

    hvt_pkg::div_pipe_t pre_next, pre_reg;
    logic               pre_v_reg;
    hvt_pkg::div_pipe_t dpipe [NDIV+1];
    logic               dvalid [NDIV+1];

    logic        out_v_reg;
    logic [95:0] out_data_reg, out_data_next;
    logic [1:0]  out_user_reg, out_user_next;

    assign en        = !out_v_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // Matrix registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < hvt_pkg::NUM_REGS; i++)
            begin
                if (i == 0 || i == 5)
                    regs_reg[i] <= ONE;
                else if (i == 2 || i == 7)
                    regs_reg[i] <= ONE << 32;
                else
                    regs_reg[i] <= 64'd0;
            end
        end
        else if (cfg_valid && cfg_index < hvt_pkg::CFG_IDX_W'(hvt_pkg::NUM_REGS))
        begin
            regs_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    // Row multiply-accumulate
    for (genvar r = 0; r < 4; r++)
    begin : g_row
        hvt_row_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (s_tvalid),
            .c0        (regs_reg[2*r][31:0]),
            .c1        (regs_reg[2*r][63:32]),
            .c2        (regs_reg[2*r+1][31:0]),
            .c3        (regs_reg[2*r+1][63:32]),
            .px        (s_tdata[31:0]),
            .py        (s_tdata[63:32]),
            .pz        (s_tdata[95:64]),
            .valid_out (row_valid[r]),
            .mag       (mag[r]),
            .neg       (neg[r])
        );
    end

    // Divider setup: overflow pre-check, zero w
    always_comb
    begin
        pre_next.den     = mag[3];
        pre_next.den_neg = neg[3];
        pre_next.w_zero  = (mag[3] == 64'd0);
        for (int l = 0; l < 3; l++)
        begin
            pre_next.lane[l].rem  = mag[l];
            pre_next.lane[l].quo  = '0;
            pre_next.lane[l].neg  = neg[l];
            pre_next.lane[l].over = (mag[l] >> NDIV) >= mag[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_reg <= pre_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_v_reg <= 1'b0;
        end
        else if (en)
        begin
            pre_v_reg <= row_valid[0];
        end
    end

    assign dpipe[0]  = pre_reg;
    assign dvalid[0] = pre_v_reg;

    // Divider stages, most significant quotient bit first
    for (genvar k = 0; k < NDIV; k++)
    begin : g_div
        hvt_div_step #(.STEP(NDIV-1-k)) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (dvalid[k]),
            .pipe_in   (dpipe[k]),
            .valid_out (dvalid[k+1]),
            .pipe_out  (dpipe[k+1])
        );
    end

    // Ceiling, sign and saturation
    always_comb
    begin
        hvt_pkg::div_lane_t ln;
        logic [NDIV:0]      qc;
        logic               sat;
        logic [31:0]        val;
        sat           = 1'b0;
        out_data_next = '0;
        for (int l = 0; l < 3; l++)
        begin
            ln  = dpipe[NDIV].lane[l];
            qc  = {1'b0, ln.quo};
            val = 32'd0;
            if (ln.neg == dpipe[NDIV].den_neg)
            begin
                qc = qc + (NDIV+1)'(ln.rem != 64'd0);
                if (ln.over || qc > (NDIV+1)'(32'h7FFF_FFFF))
                begin
                    sat = 1'b1;
                    val = 32'h7FFF_FFFF;
                end
                else
                begin
                    val = qc[31:0];
                end
            end
            else
            begin
                if (ln.over || qc > (NDIV+1)'(32'h8000_0000))
                begin
                    sat = 1'b1;
                    val = 32'h8000_0000;
                end
                else
                begin
                    val = 32'd0 - qc[31:0];
                end
            end
            out_data_next[32*l +: 32] = val;
        end
        if (dpipe[NDIV].w_zero)
        begin
            out_data_next = '0;
            out_user_next = 2'b01;
        end
        else
        begin
            out_user_next = {sat, 1'b0};
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= dvalid[NDIV];
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    `ASSERT_CLK(a_wzero_clears, clk, rst_n,
        m_tvalid && m_tuser[0] |-> m_tdata == 96'd0 && !m_tuser[1])
    `ASSERT_CLK(a_accept_enters, clk, rst_n,
        s_tvalid && s_tready |=> !en || row_valid[0] || $past(en))
    `ASSERT_CLK(a_stall_holds, clk, rst_n,
        !en |=> $stable(dvalid[NDIV]) && $stable(m_tdata))
    `ASSERT_CLK(a_rows_aligned, clk, rst_n,
        row_valid == {4{row_valid[0]}})

endmodule
